>>> src/mwlr_pkg.sv
// Package for the moving-window linear regression core.
// Holds the fixed field widths and the reset window length.
// No dependencies.
package mwlr_pkg;

	localparam int SAMPLE_W  = 32;
	localparam int RES_W     = 32;
	localparam int WIN_W     = 7;
	localparam int WIN_RESET = 14;

endpackage

>>> src/mwlr_sermul.sv
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle.
// Depends on nothing but its parameters.
module mwlr_sermul #(
	parameter int AW = 48,
	parameter int MW = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [AW-1:0] a,
	input  logic        [MW-1:0] m,
	output logic                 done,
	output logic signed [AW-1:0] product
);

	logic                 busy_q;
	logic                 done_q;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] a_q;
	logic        [MW-1:0] m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (m_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			m_q   <= m;
		end else if (busy_q && (m_q != '0)) begin
			if (m_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q <<< 1;
			m_q <= m_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

>>> src/mwlr_serdiv.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero and
// saturating the quotient to 32 bits. Depends on mwlr_pkg.
module mwlr_serdiv
	import mwlr_pkg::*;
#(
	parameter int NUM_W = 59,
	parameter int DEN_W = 28
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] dividend,
	input  logic        [DEN_W-1:0] divisor,
	output logic                    done,
	output logic signed [RES_W-1:0] quotient
);

	localparam int CW = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic             neg_q;
	logic [DEN_W-1:0] dvs_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic             hi_nz;
	logic [RES_W-1:0] lo;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[NUM_W-1];
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(rem_sh - {1'b0, dvs_q}) : DEN_W'(rem_sh);
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	// Saturate the magnitude, then apply the sign.
	assign hi_nz = |quo_q[NUM_W-1:RES_W];
	assign lo    = quo_q[RES_W-1:0];

	always_comb begin
		if (neg_q) begin
			if (hi_nz || (lo[RES_W-1] && (|lo[RES_W-2:0]))) begin
				quotient = {1'b1, {(RES_W-1){1'b0}}};
			end else begin
				quotient = -$signed(lo);
			end
		end else begin
			if (hi_nz || lo[RES_W-1]) begin
				quotient = {1'b0, {(RES_W-1){1'b1}}};
			end else begin
				quotient = $signed(lo);
			end
		end
	end

	assign done = done_q;

endmodule

>>> src/moving_window_linear_regression_core.sv
// Moving-window least-squares line fit over the last N Q16.16 samples.
// A warm-up request goes straight to the result stage; a full window walks the ring,
// runs five bit-serial products and two preparation states, then two bit-serial divides.
// One request is in flight at a time; the result register lets the next request enter
// while a finished result waits. Reset clears control.
module moving_window_linear_regression_core
	import mwlr_pkg::*;
#(
	parameter int MAX_WINDOW = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       valid_res,
	output logic signed [RES_W-1:0]    slope,
	output logic signed [RES_W-1:0]    intercept,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic        [WIN_W-1:0]    window_length
);

	// Widths follow from the largest window: NW bits hold N itself.
	localparam int NW      = $clog2(MAX_WINDOW + 1);
	localparam int RW      = $clog2(MAX_WINDOW);
	localparam int SY_W    = SAMPLE_W + NW;
	localparam int SXY_W   = SAMPLE_W + 2 * NW;
	localparam int MW      = 2 * NW;
	localparam int AW      = 3 * NW + 38;
	localparam int DEN_W   = 4 * NW;
	localparam int N_RESET = (WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_WALK   = 4'd1;
	localparam logic [3:0] S_WTAIL  = 4'd2;
	localparam logic [3:0] S_MULGO  = 4'd3;
	localparam logic [3:0] S_MULW   = 4'd4;
	localparam logic [3:0] S_PREP1  = 4'd5;
	localparam logic [3:0] S_PREP2  = 4'd6;
	localparam logic [3:0] S_DIV1GO = 4'd7;
	localparam logic [3:0] S_DIV1W  = 4'd8;
	localparam logic [3:0] S_DIV2GO = 4'd9;
	localparam logic [3:0] S_DIV2W  = 4'd10;
	localparam logic [3:0] S_OUT    = 4'd11;

	// Order of the serial products.
	localparam logic [2:0] IDX_NN1  = 3'd0;
	localparam logic [2:0] IDX_DEN  = 3'd1;
	localparam logic [2:0] IDX_NSXY = 3'd2;
	localparam logic [2:0] IDX_SXSY = 3'd3;
	localparam logic [2:0] IDX_N2SY = 3'd4;

	logic [3:0]    state_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] n_new;
	logic [RW-1:0] wp_q;
	logic [RW-1:0] wp_next;
	logic [NW-1:0] fill_q;
	logic [NW-1:0] fill_next;
	logic          in_acc;
	logic          cfg_acc;

	// Sample ring; entries are only read after they have been written.
	logic signed [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];
	logic        [RW-1:0]       rd_addr_q;
	logic        [NW-1:0]       age_q;
	logic signed [SAMPLE_W-1:0] rd_data_s1;
	logic                       vld_s1;
	logic                       last_s1;

	logic signed [SY_W-1:0]  sy_q;
	logic signed [SXY_W-1:0] sxy_q;
	logic signed [SY_W-1:0]  sy_new;

	logic [2:0]           mul_idx_q;
	logic                 mul_start;
	logic signed [AW-1:0] mul_a;
	logic        [MW-1:0] mul_m;
	logic                 mul_done;
	logic signed [AW-1:0] mul_p;

	logic        [MW-1:0]    nn1_q;
	logic        [DEN_W-1:0] den1_q;
	logic        [DEN_W-1:0] iden_q;
	logic signed [AW-1:0]    p_nsxy_q;
	logic signed [AW-1:0]    p_sxsy_q;
	logic signed [AW-1:0]    p_n2sy_q;
	logic signed [AW-1:0]    diff_q;
	logic signed [AW-1:0]    num_q;
	logic signed [AW-1:0]    inum_q;

	logic                    div_start;
	logic signed [AW-1:0]    div_dvd;
	logic        [DEN_W-1:0] div_dvs;
	logic                    div_done;
	logic signed [RES_W-1:0] div_q;

	logic                    warm_q;
	logic signed [RES_W-1:0] slope_r_q;
	logic signed [RES_W-1:0] icpt_r_q;
	logic                    out_valid_q;
	logic                    valid_res_q;
	logic signed [RES_W-1:0] slope_q;
	logic signed [RES_W-1:0] intercept_q;
	logic                    out_load;

	// Handshakes. A configuration write wins over a sample in the same cycle.
	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_acc    = in_valid && in_ready;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// The requested length is clamped to the range 2 to MAX_WINDOW.
	always_comb begin
		if (window_length < WIN_W'(2)) begin
			n_new = NW'(2);
		end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
			n_new = NW'(MAX_WINDOW);
		end else begin
			n_new = NW'(window_length);
		end
	end

	assign wp_next   = ((NW'(wp_q) + NW'(1)) == n_q) ? '0 : wp_q + RW'(1);
	assign fill_next = (fill_q < n_q) ? fill_q + NW'(1) : fill_q;

	// The walk runs from the oldest sample to the newest. The running sum of
	// samples seen so far, added once for each age above zero, builds the
	// age-weighted sum without a multiplier.
	assign sy_new = sy_q + SY_W'(rd_data_s1);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ring_mem[wp_q] <= sample;
		end
		rd_data_s1 <= ring_mem[rd_addr_q];
	end

	always_comb begin
		mul_a = '0;
		mul_m = '0;
		case (mul_idx_q)
			IDX_NN1: begin
				mul_a = AW'(n_q - NW'(1));
				mul_m = MW'(n_q);
			end
			IDX_DEN: begin
				mul_a = AW'(nn1_q + MW'(n_q) - MW'(1));
				mul_m = nn1_q + MW'(n_q);
			end
			IDX_NSXY: begin
				mul_a = AW'(sxy_q);
				mul_m = MW'(n_q);
			end
			IDX_SXSY: begin
				mul_a = AW'(sy_q);
				mul_m = nn1_q >> 1;
			end
			IDX_N2SY: begin
				mul_a = AW'(sy_q);
				mul_m = MW'(n_q - NW'(2));
			end
			default: begin
				mul_a = '0;
				mul_m = '0;
			end
		endcase
	end

	assign mul_start = (state_q == S_MULGO);
	assign div_start = (state_q == S_DIV1GO) || (state_q == S_DIV2GO);
	assign div_dvd   = (state_q == S_DIV1GO) ? num_q : inum_q;
	assign div_dvs   = (state_q == S_DIV1GO) ? den1_q : iden_q;

	mwlr_sermul #(
		.AW(AW),
		.MW(MW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.m      (mul_m),
		.done   (mul_done),
		.product(mul_p)
	);

	mwlr_serdiv #(
		.NUM_W(AW),
		.DEN_W(DEN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.done    (div_done),
		.quotient(div_q)
	);

	// Control: sequencer, ring pointers and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= NW'(N_RESET);
			wp_q        <= '0;
			fill_q      <= '0;
			vld_s1      <= 1'b0;
			mul_idx_q   <= IDX_NN1;
			warm_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_WALK);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_acc) begin
						n_q    <= n_new;
						wp_q   <= '0;
						fill_q <= '0;
					end else if (in_acc) begin
						wp_q   <= wp_next;
						fill_q <= fill_next;
						if (fill_next < n_q) begin
							warm_q  <= 1'b1;
							state_q <= S_OUT;
						end else begin
							warm_q  <= 1'b0;
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (age_q == '0) begin
						state_q <= S_WTAIL;
					end
				end
				S_WTAIL: begin
					mul_idx_q <= IDX_NN1;
					state_q   <= S_MULGO;
				end
				S_MULGO: begin
					state_q <= S_MULW;
				end
				S_MULW: begin
					if (mul_done) begin
						mul_idx_q <= mul_idx_q + 3'd1;
						state_q   <= (mul_idx_q == IDX_N2SY) ? S_PREP1 : S_MULGO;
					end
				end
				S_PREP1: begin
					state_q <= S_PREP2;
				end
				S_PREP2: begin
					state_q <= S_DIV1GO;
				end
				S_DIV1GO: begin
					state_q <= S_DIV1W;
				end
				S_DIV1W: begin
					if (div_done) begin
						state_q <= S_DIV2GO;
					end
				end
				S_DIV2GO: begin
					state_q <= S_DIV2W;
				end
				S_DIV2W: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_addr_q <= wp_next;
			age_q     <= n_q - NW'(1);
			sy_q      <= '0;
			sxy_q     <= '0;
		end else if (state_q == S_WALK) begin
			rd_addr_q <= ((NW'(rd_addr_q) + NW'(1)) == n_q) ? '0 : rd_addr_q + RW'(1);
			age_q     <= age_q - NW'(1);
		end
		last_s1 <= (age_q == '0);
		if (vld_s1) begin
			sy_q <= sy_new;
			if (!last_s1) begin
				sxy_q <= sxy_q + SXY_W'(sy_new);
			end
		end
		if ((state_q == S_MULW) && mul_done) begin
			case (mul_idx_q)
				IDX_NN1:  nn1_q    <= MW'(mul_p);
				IDX_DEN:  den1_q   <= DEN_W'(mul_p);
				IDX_NSXY: p_nsxy_q <= mul_p;
				IDX_SXSY: p_sxsy_q <= mul_p;
				IDX_N2SY: p_n2sy_q <= mul_p;
				default:  nn1_q    <= nn1_q;
			endcase
		end
		// The slope divisor is taken positive, so the numerator is negated and
		// both are scaled by twelve to keep the divisor an exact integer.
		if (state_q == S_PREP1) begin
			diff_q <= p_sxsy_q - p_nsxy_q;
			iden_q <= DEN_W'(nn1_q) + (DEN_W'(n_q) << 1);
		end
		if (state_q == S_PREP2) begin
			num_q  <= (diff_q <<< 3) + (diff_q <<< 2);
			inum_q <= (AW'(sxy_q) <<< 2) + (AW'(sxy_q) <<< 1) - (p_n2sy_q <<< 1);
		end
		if ((state_q == S_DIV1W) && div_done) begin
			slope_r_q <= div_q;
		end
		if ((state_q == S_DIV2W) && div_done) begin
			icpt_r_q <= div_q;
		end
		if (out_load) begin
			valid_res_q <= !warm_q;
			slope_q     <= warm_q ? '0 : slope_r_q;
			intercept_q <= warm_q ? '0 : icpt_r_q;
		end
	end

	assign out_valid = out_valid_q;
	assign valid_res = valid_res_q;
	assign slope     = slope_q;
	assign intercept = intercept_q;

	// The fill count never passes the window length.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= n_q)
		else $error("fill count above window length");

	// The write pointer always stays inside the window.
	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		NW'(wp_q) < n_q)
		else $error("write pointer outside window");

	// Products only complete while the sequencer waits for them.
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MULW))
		else $error("unexpected multiplier completion");

	// Quotients only complete while the sequencer waits for them.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == S_DIV1W) || (state_q == S_DIV2W)))
		else $error("unexpected divider completion");

endmodule
